FILE: hdl/vgl_pkg.sv
package vgl_pkg;

    localparam int VGL_MAX_VCPUS = 64;
    localparam int VGL_MAX_CPUS  = 16;
    localparam int SLOT_W        = 6;
    localparam int CNT_W         = 7;
    localparam int CPU_W         = 4;
    localparam int PCNT_W        = 5;
    localparam int TIME_W        = 64;
    localparam int CFG_W         = 40;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PCPUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF  = 2'd2;

    localparam logic [PCNT_W-1:0] RST_NUM_PCPUS = 5'd16;
    localparam logic [CFG_W-1:0]  RST_BUSY_THR  = 40'd100000000;
    localparam logic [CFG_W-1:0]  RST_MAX_DIFF  = 40'd10000000;

    typedef struct packed {
        logic [5:0]  domain_id;
        logic [5:0]  vcpu_id;
        logic [3:0]  host_cpu;
        logic [63:0] cpu_time_ns;
        logic        last_sample;
    } t_in;

    typedef struct packed {
        logic [5:0] pin_domain;
        logic [5:0] pin_vcpu;
        logic [3:0] pin_cpu;
        logic       last_pin;
    } t_out;

    // sample word as queued between front and back
    typedef struct packed {
        t_in  smp;
        logic keep;
    } t_cmd;

    typedef struct packed {
        logic [PCNT_W-1:0] num_pcpus;
        logic [CFG_W-1:0]  busy_threshold_ns;
        logic [CFG_W-1:0]  max_diff_ns;
    } t_cfg;

    typedef struct packed {
        logic [5:0] domain_id;
        logic [5:0] vcpu_id;
        logic [3:0] host_cpu;
    } t_slot;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_BLK,
        S_BRD,
        S_BEMIT,
        S_DRD,
        S_DCALC,
        S_SCAN,
        S_SSTART,
        S_SRD,
        S_SCMP,
        S_MIN,
        S_SEMIT,
        S_CRD,
        S_CWR
    } t_bstate;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic logic [PCNT_W-1:0] eff_pcpus(input logic [PCNT_W-1:0] v);
        logic [PCNT_W-1:0] r;
        if (v == '0) begin
            r = PCNT_W'(1);
        end else if (v > PCNT_W'(VGL_MAX_CPUS)) begin
            r = PCNT_W'(VGL_MAX_CPUS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/vgl_front.sv
module vgl_front import vgl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd             r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_qcnt, n_qcnt;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             w_push, w_pop;

    assign o_in_ready  = (r_qcnt != 2'd2);
    assign o_cmd_valid = (r_qcnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp   = r_wp ^ w_push;
        n_rp   = r_rp ^ w_pop;
        n_qcnt = r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
        n_fill = r_fill;
        if (w_push) begin
            // count kept samples of the open round; last word restarts it
            if (i_in_data.last_sample) begin
                n_fill = '0;
            end else if (r_fill < CNT_W'(VGL_MAX_VCPUS)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_qcnt <= n_qcnt;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].smp  <= i_in_data;
            r_q[r_wp].keep <= (r_fill < CNT_W'(VGL_MAX_VCPUS));
        end
    end

endmodule

FILE: hdl/vgl_back.sv
module vgl_back import vgl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_bstate             r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_prev_cnt, n_prev_cnt;
    logic                r_have_prev, n_have_prev;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_blk, n_blk;
    logic [CNT_W-1:0]    r_bcnt, n_bcnt;
    logic [CPU_W-1:0]    r_pcpu, n_pcpu;
    logic [PCNT_W-1:0]   r_j, n_j;
    logic [TIME_W-1:0]   r_mx, n_mx;
    logic [TIME_W-1:0]   r_mn, n_mn;
    logic                r_above, n_above;
    logic [SLOT_W-1:0]   r_best, n_best;
    logic [TIME_W-1:0]   r_bestd, n_bestd;
    logic                r_bv, n_bv;
    logic [CPU_W-1:0]    r_bestc, n_bestc;
    logic [TIME_W-1:0]   r_minv, n_minv;
    logic [VGL_MAX_VCPUS-1:0] r_sel, n_sel;
    logic [TIME_W-1:0]   r_busy [VGL_MAX_CPUS];
    logic [TIME_W-1:0]   n_busy [VGL_MAX_CPUS];
    logic [TIME_W-1:0]   r_load [VGL_MAX_CPUS];
    logic [TIME_W-1:0]   n_load [VGL_MAX_CPUS];
    logic                r_ovalid, n_ovalid;
    t_out                r_out, n_out;

    t_slot               m_info [VGL_MAX_VCPUS];
    logic [TIME_W-1:0]   m_cur  [VGL_MAX_VCPUS];
    logic [TIME_W-1:0]   m_prev [VGL_MAX_VCPUS];
    logic [TIME_W-1:0]   m_dlt  [VGL_MAX_VCPUS];
    t_slot               r_info_q;
    logic [TIME_W-1:0]   r_cur_q, r_prev_q, r_dlt_q;

    logic [SLOT_W-1:0]   w_ra;
    logic                w_smp_we, w_prev_we, w_dlt_we;
    logic [TIME_W-1:0]   w_dlt;
    logic [PCNT_W-1:0]   w_p;
    logic                w_ofree;
    logic [11:0]         w_prod;
    logic [TIME_W-1:0]   w_b;

    assign w_p         = eff_pcpus(i_cfg.num_pcpus);
    assign w_ofree     = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cmd_pop   = (r_state == S_LOAD) && i_cmd_valid;
    assign w_dlt       = r_cur_q - r_prev_q;
    assign w_prod      = {5'b0, r_blk} * {7'b0, w_p};
    assign w_b         = r_busy[r_j[CPU_W-1:0]];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_prev_cnt  = r_prev_cnt;
        n_have_prev = r_have_prev;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_blk       = r_blk;
        n_bcnt      = r_bcnt;
        n_pcpu      = r_pcpu;
        n_j         = r_j;
        n_mx        = r_mx;
        n_mn        = r_mn;
        n_above     = r_above;
        n_best      = r_best;
        n_bestd     = r_bestd;
        n_bv        = r_bv;
        n_bestc     = r_bestc;
        n_minv      = r_minv;
        n_sel       = r_sel;
        n_busy      = r_busy;
        n_load      = r_load;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_out       = r_out;
        w_ra        = r_idx[SLOT_W-1:0];
        w_smp_we    = 1'b0;
        w_prev_we   = 1'b0;
        w_dlt_we    = 1'b0;

        case (r_state)
            S_LOAD: begin
                w_ra = r_cnt[SLOT_W-1:0];
                if (i_cmd_valid) begin
                    if (i_cmd.keep) begin
                        w_smp_we = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                    end
                    if (i_cmd.smp.last_sample) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                for (int k = 0; k < VGL_MAX_CPUS; k++) begin
                    n_busy[k] = '0;
                    n_load[k] = '0;
                end
                n_idx = '0;
                if (!r_have_prev || r_prev_cnt != r_cnt) begin
                    n_blk   = CNT_W'(1);
                    n_state = S_BLK;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_BLK: begin
                // smallest block size that covers all vCPUs
                if (w_prod >= {5'b0, r_cnt}) begin
                    n_idx   = '0;
                    n_bcnt  = '0;
                    n_pcpu  = '0;
                    n_state = S_BRD;
                end else begin
                    n_blk = r_blk + 1'b1;
                end
            end
            S_BRD: begin
                if (r_idx == r_cnt) begin
                    n_idx   = '0;
                    n_state = S_CRD;
                end else begin
                    n_state = S_BEMIT;
                end
            end
            S_BEMIT: begin
                if (w_ofree) begin
                    n_ovalid         = 1'b1;
                    n_out.pin_domain = r_info_q.domain_id;
                    n_out.pin_vcpu   = r_info_q.vcpu_id;
                    n_out.pin_cpu    = r_pcpu;
                    n_out.last_pin   = (r_idx + 1'b1 == r_cnt);
                    if (r_bcnt + 1'b1 == r_blk) begin
                        n_bcnt = '0;
                        n_pcpu = r_pcpu + 1'b1;
                    end else begin
                        n_bcnt = r_bcnt + 1'b1;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_DRD: begin
                if (r_idx == r_cnt) begin
                    n_j     = '0;
                    n_mx    = '0;
                    n_mn    = '1;
                    n_above = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DCALC;
                end
            end
            S_DCALC: begin
                w_dlt_we = 1'b1;
                if ({1'b0, r_info_q.host_cpu} < w_p) begin
                    n_busy[r_info_q.host_cpu] = sat_add(r_busy[r_info_q.host_cpu], w_dlt);
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_DRD;
            end
            S_SCAN: begin
                if (r_j == w_p) begin
                    if (r_above && (r_mx - r_mn) > {24'b0, i_cfg.max_diff_ns}) begin
                        n_pos   = '0;
                        n_sel   = '0;
                        n_state = S_SSTART;
                    end else begin
                        n_idx   = '0;
                        n_state = S_CRD;
                    end
                end else begin
                    if (w_b > {24'b0, i_cfg.busy_threshold_ns}) n_above = 1'b1;
                    if (w_b > r_mx) n_mx = w_b;
                    if (w_b < r_mn) n_mn = w_b;
                    n_j = r_j + 1'b1;
                end
            end
            S_SSTART: begin
                n_idx   = '0;
                n_bv    = 1'b0;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (r_idx == r_cnt) begin
                    n_j     = PCNT_W'(1);
                    n_bestc = '0;
                    n_minv  = r_load[0];
                    n_state = S_MIN;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                // strict compare keeps the lowest slot on equal deltas
                if (!r_sel[r_idx[SLOT_W-1:0]] && (!r_bv || r_dlt_q > r_bestd)) begin
                    n_best  = r_idx[SLOT_W-1:0];
                    n_bestd = r_dlt_q;
                    n_bv    = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_SRD;
            end
            S_MIN: begin
                w_ra = r_best;
                if (r_j == w_p) begin
                    n_state = S_SEMIT;
                end else begin
                    if (r_load[r_j[CPU_W-1:0]] < r_minv) begin
                        n_minv  = r_load[r_j[CPU_W-1:0]];
                        n_bestc = r_j[CPU_W-1:0];
                    end
                    n_j = r_j + 1'b1;
                end
            end
            S_SEMIT: begin
                // hold the chosen slot on the read port while the output stalls
                w_ra = r_best;
                if (w_ofree) begin
                    n_ovalid         = 1'b1;
                    n_out.pin_domain = r_info_q.domain_id;
                    n_out.pin_vcpu   = r_info_q.vcpu_id;
                    n_out.pin_cpu    = r_bestc;
                    n_out.last_pin   = (r_pos + 1'b1 == r_cnt);
                    n_load[r_bestc]  = sat_add(r_minv, r_bestd);
                    n_sel[r_best]    = 1'b1;
                    n_pos            = r_pos + 1'b1;
                    if (r_pos + 1'b1 == r_cnt) begin
                        n_idx   = '0;
                        n_state = S_CRD;
                    end else begin
                        n_state = S_SSTART;
                    end
                end
            end
            S_CRD: begin
                if (r_idx == r_cnt) begin
                    n_prev_cnt  = r_cnt;
                    n_have_prev = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_LOAD;
                end else begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                w_prev_we = 1'b1;
                n_idx     = r_idx + 1'b1;
                n_state   = S_CRD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_prev_cnt  <= '0;
            r_have_prev <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_prev_cnt  <= n_prev_cnt;
            r_have_prev <= n_have_prev;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_blk   <= n_blk;
        r_bcnt  <= n_bcnt;
        r_pcpu  <= n_pcpu;
        r_j     <= n_j;
        r_mx    <= n_mx;
        r_mn    <= n_mn;
        r_above <= n_above;
        r_best  <= n_best;
        r_bestd <= n_bestd;
        r_bv    <= n_bv;
        r_bestc <= n_bestc;
        r_minv  <= n_minv;
        r_sel   <= n_sel;
        r_busy  <= n_busy;
        r_load  <= n_load;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_smp_we) begin
            m_info[w_ra] <= {i_cmd.smp.domain_id, i_cmd.smp.vcpu_id, i_cmd.smp.host_cpu};
            m_cur[w_ra]  <= i_cmd.smp.cpu_time_ns;
        end
        if (w_prev_we) begin
            m_prev[w_ra] <= r_cur_q;
        end
        if (w_dlt_we) begin
            m_dlt[w_ra] <= w_dlt;
        end
        r_info_q <= m_info[w_ra];
        r_cur_q  <= m_cur[w_ra];
        r_prev_q <= m_prev[w_ra];
        r_dlt_q  <= m_dlt[w_ra];
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VGL_MAX_VCPUS))
        else $error("slot count beyond capacity");

    a_block_cpu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BEMIT |-> {1'b0, r_pcpu} < w_p)
        else $error("block pin beyond cpu count");

    a_best_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEMIT |-> r_bv)
        else $error("no unassigned vcpu found");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SSTART |-> r_pos < r_cnt)
        else $error("assignment past vcpu count");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop && i_cmd.smp.last_sample |=> r_state == S_START)
        else $error("round close missed");

endmodule

FILE: hdl/vcpu_greedy_load_balancer.sv
// channel  | dir | handshake                  | word
// ---------+-----+----------------------------+---------------------------------
// sample   | in  | i_in_valid / o_in_ready    | i_in_data (t_in)
// pin      | out | o_out_valid / i_out_ready  | o_out_data (t_out)
// config   | in  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A sample is stored as the back end pops it; a two-word queue holds samples while a round closes.
// A round with n vCPUs on p CPUs closes by block pinning, by no rebalance when none is due, or
// by rebalancing; when rebalancing, the delta memory is scanned once for each pin.
// Reset (i_rst_n low, synchronous) clears control state; stored samples are undefined.
// A stalled pin output holds the back end; samples still queue until the queue is full.
module vcpu_greedy_load_balancer import vgl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_pcpus         <= RST_NUM_PCPUS;
            r_cfg.busy_threshold_ns <= RST_BUSY_THR;
            r_cfg.max_diff_ns       <= RST_MAX_DIFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_PCPUS: r_cfg.num_pcpus         <= i_cfg_data[PCNT_W-1:0];
                CFG_BUSY_THR:  r_cfg.busy_threshold_ns <= i_cfg_data;
                CFG_MAX_DIFF:  r_cfg.max_diff_ns       <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    vgl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    vgl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sim/tb.sv
module tb;
    import vgl_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    vcpu_greedy_load_balancer uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [PCNT_W-1:0] bal_pcpus;
    logic [CFG_W-1:0]  bal_busy_thr;
    logic [CFG_W-1:0]  bal_max_diff;
    logic [63:0]       slot_last_ns [VGL_MAX_VCPUS];
    logic [63:0]       slot_now_ns [VGL_MAX_VCPUS];
    t_slot             slot_info [VGL_MAX_VCPUS];
    int                slots_open;
    int                prev_slots;
    bit                have_prev;

    t_out pin_queue[$];
    int   errors;
    int   pins_seen;
    int   rounds_closed;
    int   balanced_rounds;
    int   items_sent;
    bit   quiet;
    int   idle_cycles = 0;

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    task automatic close_round();
        int n;
        int p;
        int blk;
        int best;
        int pos;
        int v;
        logic [63:0] delta [VGL_MAX_VCPUS];
        logic [63:0] busy [VGL_MAX_CPUS];
        logic [63:0] load [VGL_MAX_CPUS];
        int ord [VGL_MAX_VCPUS];
        logic [63:0] mx;
        logic [63:0] mn;
        bit above;
        t_out w;
        n = slots_open;
        p = (bal_pcpus == 0) ? 1 : (bal_pcpus > VGL_MAX_CPUS) ? VGL_MAX_CPUS : bal_pcpus;
        rounds_closed++;
        for (int j = 0; j < VGL_MAX_CPUS; j++) begin
            busy[j] = '0;
            load[j] = '0;
        end
        if (!have_prev || prev_slots != n) begin
            blk = (n + p - 1) / p;
            if (blk == 0) blk = 1;
            for (int i = 0; i < n; i++) begin
                w.pin_domain = slot_info[i].domain_id;
                w.pin_vcpu = slot_info[i].vcpu_id;
                w.pin_cpu = 4'(i / blk);
                w.last_pin = (i + 1 == n);
                pin_queue.push_back(w);
            end
        end else begin
            mx = '0;
            mn = '1;
            above = 0;
            for (int i = 0; i < n; i++) begin
                delta[i] = slot_now_ns[i] - slot_last_ns[i];
                if (slot_info[i].host_cpu < p)
                    busy[slot_info[i].host_cpu] = add_sat(busy[slot_info[i].host_cpu], delta[i]);
            end
            for (int j = 0; j < p; j++) begin
                if (busy[j] > 64'(bal_busy_thr)) above = 1;
                if (busy[j] > mx) mx = busy[j];
                if (busy[j] < mn) mn = busy[j];
            end
            if (above && (mx - mn) > 64'(bal_max_diff)) begin
                balanced_rounds++;
                // stable insertion sort, largest delta first
                for (int i = 0; i < n; i++) begin
                    v = i;
                    pos = i;
                    while (pos > 0 && delta[ord[pos-1]] < delta[v]) begin
                        ord[pos] = ord[pos-1];
                        pos--;
                    end
                    ord[pos] = v;
                end
                for (int i = 0; i < n; i++) begin
                    best = 0;
                    for (int j = 1; j < p; j++)
                        if (load[j] < load[best]) best = j;
                    w.pin_domain = slot_info[ord[i]].domain_id;
                    w.pin_vcpu = slot_info[ord[i]].vcpu_id;
                    w.pin_cpu = 4'(best);
                    w.last_pin = (i + 1 == n);
                    pin_queue.push_back(w);
                    load[best] = add_sat(load[best], delta[ord[i]]);
                end
            end
        end
        for (int i = 0; i < n; i++) slot_last_ns[i] = slot_now_ns[i];
        prev_slots = n;
        have_prev = 1;
        slots_open = 0;
    endtask

    task automatic store_sample(t_in s);
        if (slots_open < VGL_MAX_VCPUS) begin
            slot_info[slots_open] = '{s.domain_id, s.vcpu_id, s.host_cpu};
            slot_now_ns[slots_open] = s.cpu_time_ns;
            slots_open++;
        end
        if (s.last_sample) close_round();
    endtask

    // pin checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pins_seen++;
            if (pin_queue.size() == 0) begin
                $display("%0t: unexpected pin word, expected none, actual %p", $time, o_out_data);
                errors++;
            end else begin
                if (o_out_data !== pin_queue[0]) begin
                    $display("%0t: pin mismatch, expected %p, actual %p",
                             $time, pin_queue[0], o_out_data);
                    errors++;
                end
                void'(pin_queue.pop_front());
            end
        end
        i_out_ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 100000) begin
            $display("%0t: watchdog expired with %0d pins pending", $time, pin_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays high after the accept so the next word can follow at once
    task automatic send(t_in s);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        store_sample(s);
    endtask

    task automatic drain(int settle);
        i_in_valid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        // close-of-round work may still run without producing pins
        drain(9000);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_PCPUS: bal_pcpus = val[PCNT_W-1:0];
            CFG_BUSY_THR:  bal_busy_thr = val;
            CFG_MAX_DIFF:  bal_max_diff = val;
            default: ;
        endcase
    endtask

    // one round of n samples; times grow by random deltas per slot
    logic [63:0] clock_of [VGL_MAX_VCPUS];

    task automatic run_round(int n, int hot_cpus, bit noisy);
        t_in s;
        int k;
        for (int i = 0; i < n; i++) begin
            // samples past capacity reuse the top clock, they are dropped anyway
            k = (i < VGL_MAX_VCPUS) ? i : VGL_MAX_VCPUS - 1;
            s.domain_id = 6'($urandom);
            s.vcpu_id = 6'($urandom);
            s.host_cpu = (hot_cpus > 0) ? 4'($urandom_range(0, hot_cpus - 1)) : 4'($urandom);
            if (noisy && $urandom_range(0, 5) == 0)
                clock_of[k] = {$urandom, $urandom};
            else
                clock_of[k] = clock_of[k] + 64'($urandom_range(0, 400)) * 64'd1000000;
            s.cpu_time_ns = clock_of[k];
            s.last_sample = (i == n - 1);
            send(s);
        end
    endtask

    typedef struct {
        t_in  smp;
        bit   has_pin;
        t_out pin;
    } t_dir_row;

    t_dir_row dir_rows[$];

    initial begin
        t_in s;
        int n;
        int rep;
        t_out w;
        t_out got;
        errors = 0;
        pins_seen = 0;
        rounds_closed = 0;
        balanced_rounds = 0;
        items_sent = 0;
        quiet = 0;
        bal_pcpus = RST_NUM_PCPUS;
        bal_busy_thr = RST_BUSY_THR;
        bal_max_diff = RST_MAX_DIFF;
        slots_open = 0;
        prev_slots = 0;
        have_prev = 0;
        for (int i = 0; i < VGL_MAX_VCPUS; i++) clock_of[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: single-sample round pins to cpu 0 with last set
        s = '{6'd63, 6'd63, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1};
        w = '{6'd63, 6'd63, 4'd0, 1'b1};
        dir_rows.push_back('{s, 1, w});
        s = '{6'd0, 6'd0, 4'd0, 64'd0, 1'b1};
        w = '{6'd0, 6'd0, 4'd0, 1'b1};
        // counter going back from all ones: delta wraps to one, below threshold so no pins
        dir_rows.push_back('{s, 0, w});
        foreach (dir_rows[r]) begin
            if (dir_rows[r].has_pin) begin
                send(dir_rows[r].smp);
                got = (pin_queue.size() == 0) ? '0 : pin_queue[$];
                if (pin_queue.size() == 0 || got !== dir_rows[r].pin) begin
                    $display("%0t: table row %0d mismatch, expected %p, actual %p", $time, r,
                             dir_rows[r].pin, got);
                    errors++;
                end
            end else begin
                send(dir_rows[r].smp);
            end
        end
        drain(50);

        // block pinning on two CPUs then a rebalance with foreign host CPUs
        write_reg(CFG_NUM_PCPUS, 40'd2);
        write_reg(CFG_BUSY_THR, 40'd0);
        write_reg(CFG_MAX_DIFF, 40'd0);
        run_round(5, 0, 0);
        run_round(5, 4, 0);
        run_round(5, 2, 0);
        // count changes, then saturating sums
        s = '{6'd1, 6'd2, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0};
        send(s);
        s = '{6'd3, 6'd4, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1};
        send(s);
        s = '{6'd1, 6'd2, 4'd0, 64'h7FFF_FFFF_FFFF_FFF0, 1'b0};
        send(s);
        s = '{6'd3, 6'd4, 4'd0, 64'h7FFF_FFFF_FFFF_FFF0, 1'b1};
        send(s);

        // pause sender until every pin is out, then pin count extremes
        write_reg(CFG_NUM_PCPUS, 40'd0);
        run_round(3, 0, 0);
        run_round(3, 0, 0);
        write_reg(CFG_NUM_PCPUS, 40'd31);
        write_reg(CFG_BUSY_THR, 40'hFF_FFFF_FFFF);
        write_reg(CFG_MAX_DIFF, 40'hFF_FFFF_FFFF);
        run_round(4, 0, 0);
        run_round(4, 0, 1);
        write_reg(CFG_NUM_PCPUS, 40'd16);
        // too many samples: 66 in a round, extras dropped
        run_round(66, 0, 0);
        write_reg(CFG_BUSY_THR, 40'd100000000);
        write_reg(CFG_MAX_DIFF, 40'd10000000);

        // random part: repeated rounds of the same size reach balancing
        while (items_sent < 216) begin
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_NUM_PCPUS, 40'($urandom_range(1, 16)));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_BUSY_THR, 40'($urandom_range(0, 300)) * 40'd1000000);
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_MAX_DIFF, 40'($urandom_range(0, 200)) * 40'd1000000);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            rep = $urandom_range(2, 4);
            // trim the round size near the end of the item budget
            if (n * rep > 216 - items_sent) n = (216 - items_sent) / rep + 1;
            repeat (rep)
                run_round(n, $urandom_range(0, 3), $urandom_range(0, 9) == 0);
        end
        quiet = 1;
        run_round(6, 2, 0);
        run_round(6, 2, 0);

        drain(9000);
        $display("Closed %0d rounds, %0d of them rebalanced, and checked %0d pin words.",
                 rounds_closed, balanced_rounds, pins_seen);
        if (errors == 0 && pin_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
